// ===== rtl/core/lpd_pkg.sv =====
package lpd_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CORE  = 2'd0,
		KIND_PAD   = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} evt_kind_t;

	// Packet type codes
	localparam logic [7:0] PKT_CORE  = 8'd1;
	localparam logic [7:0] PKT_CFG   = 8'd2;
	localparam logic [7:0] PKT_PAD   = 8'd3;
	localparam logic [7:0] PKT_WRITE = 8'd4;
	localparam logic [7:0] PKT_READ  = 8'd5;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;

	// Positions within a packet
	localparam int POS_HUNT     = 0;
	localparam int POS_LEN_HI   = 1;
	localparam int POS_LEN_LO   = 2;
	localparam int POS_TYPE     = 3;
	localparam int POS_READ_END = 5;
	localparam int POS_DATA     = 6;
	localparam int POS_PAD_END  = 7;

	// Config string skip counts modulo this many bits
	localparam int SKIP_POS_W = 10;

	typedef struct packed {
		evt_kind_t   event_kind;
		logic [7:0]  core_ident;
		logic [15:0] pad_one;
		logic [15:0] pad_two;
		logic        drive_sel;
		logic [14:0] sector_num;
		logic [7:0]  data_byte;
		logic [8:0]  byte_index;
		logic        last_byte;
	} evt_t;

endpackage

// ===== rtl/core/lpd_ifs.sv =====
interface lpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] drives_mounted;

	modport source (output valid, output drives_mounted, input ready);
	modport sink (input valid, input drives_mounted, output ready);
endinterface

interface lpd_evt_if;
	logic               valid;
	logic               ready;
	lpd_pkg::evt_kind_t event_kind;
	logic [7:0]         core_ident;
	logic [15:0]        pad_one;
	logic [15:0]        pad_two;
	logic               drive_sel;
	logic [14:0]        sector_num;
	logic [7:0]         data_byte;
	logic [8:0]         byte_index;
	logic               last_byte;

	modport source (output valid, output event_kind, output core_ident, output pad_one,
		output pad_two, output drive_sel, output sector_num, output data_byte,
		output byte_index, output last_byte, input ready);
	modport sink (input valid, input event_kind, input core_ident, input pad_one,
		input pad_two, input drive_sel, input sector_num, input data_byte,
		input byte_index, input last_byte, output ready);
endinterface

// ===== rtl/core/link_packet_deframer.sv =====
// Link packet deframer: takes one received byte per cycle on rx while the
// result side has room, hunts for the sync byte, reads length and type, and
// reports core id, joypad words, floppy sector write bytes (only for drives
// marked in drives_mounted) and floppy read requests on evt. Throughput is
// one byte per clock while evt is not stalled; a byte is held in the input
// register and its result is then loaded into the result register. The cfg
// port is always ready and takes drives_mounted. SECTOR_BYTES sets the number
// of data bytes in a sector write and, with SKIP_POS_W, the width of the
// position counter.
module link_packet_deframer #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	lpd_cfg_if.sink   cfg,
	lpd_rx_if.sink    rx,
	lpd_evt_if.source evt
);
	import lpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       space;
	logic       step;
	logic       fire;
	evt_t       evt_d;

	// Process the held byte when the result side has room
	assign step = valid_s1 && space;

	lpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.step     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpd_parser #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.byte_s1 (byte_s1),
		.fire    (fire),
		.evt_d   (evt_d)
	);

	lpd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.fire   (fire),
		.evt_d  (evt_d),
		.space  (space),
		.evt    (evt)
	);

	// A stalled result blocks the parser
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && !evt.ready |-> !step)
		else $error("parser advanced while result stalled");

	// A new result comes only from a processed byte that fired
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(evt.valid) |-> $past(step && fire))
		else $error("result without a source byte");

	// The last flag belongs to sector write bytes only
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.last_byte |-> evt.event_kind == KIND_WRITE)
		else $error("last flag on a non-write result");
endmodule

// ===== rtl/core/lpd_in_stage.sv =====
module lpd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	lpd_rx_if.sink     rx,
	input  logic       step,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	// Take a new item when the stage is empty or its item moves on
	assign rx.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Hold the byte
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end
endmodule

// ===== rtl/core/lpd_parser.sv =====
module lpd_parser #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	lpd_cfg_if.sink       cfg,
	input  logic          step,
	input  logic [7:0]    byte_s1,
	output logic          fire,
	output lpd_pkg::evt_t evt_d
);
	import lpd_pkg::*;

	localparam int PW = ($clog2(SECTOR_BYTES + POS_DATA) > SKIP_POS_W) ?
		$clog2(SECTOR_BYTES + POS_DATA) : SKIP_POS_W;
	localparam logic [PW-1:0] P_HUNT     = PW'(POS_HUNT);
	localparam logic [PW-1:0] P_LEN_HI   = PW'(POS_LEN_HI);
	localparam logic [PW-1:0] P_LEN_LO   = PW'(POS_LEN_LO);
	localparam logic [PW-1:0] P_TYPE     = PW'(POS_TYPE);
	localparam logic [PW-1:0] P_READ_END = PW'(POS_READ_END);
	localparam logic [PW-1:0] P_DATA     = PW'(POS_DATA);
	localparam logic [PW-1:0] P_PAD_END  = PW'(POS_PAD_END);
	localparam logic [PW-1:0] LAST_IDX   = PW'(SECTOR_BYTES - 1);

	logic [PW-1:0] pos_q, pos_d;
	logic [15:0]   len_q;
	logic [7:0]    type_q;
	logic [1:0]    mounted_q;
	logic [7:0]    head0_q, head1_q, head2_q;
	logic          len_hi_we, len_lo_we, type_we;
	logic          head0_we, head1_we, head2_we;

	assign cfg.ready = 1'b1;

	// Decode one byte against the packet position
	always_comb begin
		logic [16:0]         skip_end;
		logic [SKIP_POS_W-1:0] skip_next;
		logic [PW-1:0]       idx;
		logic                last;

		skip_end  = {1'b0, len_q} + 17'd2;
		skip_next = pos_q[SKIP_POS_W-1:0] + SKIP_POS_W'(1);
		idx       = pos_q - P_DATA;
		last      = idx >= LAST_IDX;

		pos_d     = pos_q;
		fire      = 1'b0;
		evt_d     = '0;
		len_hi_we = 1'b0;
		len_lo_we = 1'b0;
		type_we   = 1'b0;
		head0_we  = 1'b0;
		head1_we  = 1'b0;
		head2_we  = 1'b0;

		if (pos_q == P_HUNT) begin
			if (byte_s1 == SYNC_BYTE) begin
				pos_d = P_LEN_HI;
			end
		end else if (pos_q == P_LEN_HI) begin
			len_hi_we = 1'b1;
			pos_d     = P_LEN_LO;
		end else if (pos_q == P_LEN_LO) begin
			len_lo_we = 1'b1;
			pos_d     = P_TYPE;
		end else if (pos_q == P_TYPE) begin
			type_we = 1'b1;
			pos_d   = pos_q + PW'(1);
		end else begin
			case (type_q)
				PKT_CORE: begin
					fire             = 1'b1;
					evt_d.event_kind = KIND_CORE;
					evt_d.core_ident = byte_s1;
					pos_d            = P_HUNT;
				end
				PKT_CFG: begin
					// Skip to length+2, or until the count wraps
					if (17'(pos_q) == skip_end) begin
						pos_d = P_HUNT;
					end else begin
						pos_d = PW'(skip_next);
					end
				end
				PKT_PAD: begin
					if (pos_q >= P_PAD_END) begin
						fire             = 1'b1;
						evt_d.event_kind = KIND_PAD;
						evt_d.pad_one    = {head0_q, head1_q};
						evt_d.pad_two    = {head2_q, byte_s1};
						pos_d            = P_HUNT;
					end else begin
						head0_we = pos_q[1:0] == 2'd0;
						head1_we = pos_q[1:0] == 2'd1;
						head2_we = pos_q[1:0] == 2'd2;
						pos_d    = pos_q + PW'(1);
					end
				end
				PKT_WRITE: begin
					if (pos_q < P_DATA) begin
						head0_we = pos_q[1:0] == 2'd0;
						head1_we = pos_q[1:0] == 2'd1;
						pos_d    = pos_q + PW'(1);
					end else begin
						// Emit the data byte only for a mounted drive
						if (mounted_q[head0_q[7]]) begin
							fire             = 1'b1;
							evt_d.event_kind = KIND_WRITE;
							evt_d.drive_sel  = head0_q[7];
							evt_d.sector_num = {head0_q[6:0], head1_q};
							evt_d.data_byte  = byte_s1;
							evt_d.byte_index = idx[8:0];
							evt_d.last_byte  = last;
						end
						pos_d = last ? P_HUNT : pos_q + PW'(1);
					end
				end
				PKT_READ: begin
					if (pos_q >= P_READ_END) begin
						fire             = 1'b1;
						evt_d.event_kind = KIND_READ;
						evt_d.drive_sel  = head0_q[7];
						evt_d.sector_num = {head0_q[6:0], byte_s1};
						pos_d            = P_HUNT;
					end else begin
						head0_we = 1'b1;
						pos_d    = pos_q + PW'(1);
					end
				end
				default: begin
					// Unknown type: drop back to sync hunting
					pos_d = P_HUNT;
				end
			endcase
		end
	end

	// Advance packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= P_HUNT;
			len_q     <= '0;
			type_q    <= '0;
			mounted_q <= '0;
		end else begin
			if (cfg.valid) begin
				mounted_q <= cfg.drives_mounted;
			end
			if (step) begin
				pos_q <= pos_d;
				if (len_hi_we) begin
					len_q[15:8] <= byte_s1;
				end
				if (len_lo_we) begin
					len_q[7:0] <= byte_s1;
				end
				if (type_we) begin
					type_q <= byte_s1;
				end
			end
		end
	end

	// Hold payload head bytes
	always_ff @(posedge clk) begin
		if (step && head0_we) begin
			head0_q <= byte_s1;
		end
		if (step && head1_we) begin
			head1_q <= byte_s1;
		end
		if (step && head2_we) begin
			head2_q <= byte_s1;
		end
	end
endmodule

// ===== rtl/core/lpd_out_stage.sv =====
module lpd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          fire,
	input  lpd_pkg::evt_t evt_d,
	output logic          space,
	lpd_evt_if.source     evt
);
	import lpd_pkg::*;

	evt_t evt_q;

	assign space = !evt.valid || evt.ready;

	// Load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else if (space) begin
			evt.valid <= step && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fire) begin
			evt_q <= evt_d;
		end
	end

	assign evt.event_kind = evt_q.event_kind;
	assign evt.core_ident = evt_q.core_ident;
	assign evt.pad_one    = evt_q.pad_one;
	assign evt.pad_two    = evt_q.pad_two;
	assign evt.drive_sel  = evt_q.drive_sel;
	assign evt.sector_num = evt_q.sector_num;
	assign evt.data_byte  = evt_q.data_byte;
	assign evt.byte_index = evt_q.byte_index;
	assign evt.last_byte  = evt_q.last_byte;
endmodule

// ===== test/link_packet_deframer_tb.sv =====
module link_packet_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam int SECTOR_BYTES = 512;
	localparam int WATCHDOG_LIMIT = 3000;
	// let results leave the pipeline; allow a margin
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES = 40;

	typedef enum {
		PLAN_CORE,
		PLAN_PAD,
		PLAN_READ,
		PLAN_SKIP,
		PLAN_WRITE,
		PLAN_WRAP,
		PLAN_ODD,
		PLAN_NOISE
	} plan_t;

	logic clk;
	logic arst_n;

	lpd_cfg_if cfg();
	lpd_rx_if  rx();
	lpd_evt_if evt();

	link_packet_deframer #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.rx    (rx),
		.evt   (evt)
	);

	// Parser state mirrored in the bench
	logic [SKIP_POS_W-1:0] rx_pos;
	logic [15:0]           rx_len;
	logic [7:0]            rx_type;
	logic [7:0]            rx_head [4];
	logic [1:0]            mounted_drives;

	evt_t pending_events [$];
	int   mismatches;
	int   bytes_sent;
	int   quiet_cycles;
	int   hold_left;
	bit   steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int stall_len();
		return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic evt_t make_event(evt_kind_t kind, logic [7:0] ident, logic [15:0] p1,
		logic [15:0] p2, logic drv, logic [14:0] sec);
		evt_t e;
		e = '0;
		e.event_kind = kind;
		e.core_ident = ident;
		e.pad_one = p1;
		e.pad_two = p2;
		e.drive_sel = drv;
		e.sector_num = sec;
		return e;
	endfunction

	// Advance the mirrored parser by one byte; return 1 when it reports an event
	function automatic bit parse_byte(input logic [7:0] b, output evt_t r);
		logic [SKIP_POS_W-1:0] off;
		logic                  last;
		logic                  drv;
		bit                    hit;
		hit = 1'b0;
		r = '0;
		if (rx_pos == POS_HUNT) begin
			if (b == SYNC_BYTE)
				rx_pos = SKIP_POS_W'(POS_LEN_HI);
		end else if (rx_pos == POS_LEN_HI) begin
			rx_len = {b, 8'h00};
			rx_pos = SKIP_POS_W'(POS_LEN_LO);
		end else if (rx_pos == POS_LEN_LO) begin
			rx_len[7:0] = b;
			rx_pos = SKIP_POS_W'(POS_TYPE);
		end else if (rx_pos == POS_TYPE) begin
			rx_type = b;
			rx_pos = SKIP_POS_W'(POS_TYPE + 1);
		end else if (rx_type == PKT_CORE) begin
			r = make_event(KIND_CORE, b, '0, '0, 1'b0, '0);
			hit = 1'b1;
			rx_pos = SKIP_POS_W'(POS_HUNT);
		end else if (rx_type == PKT_CFG) begin
			// skip until length+2; a target never met wraps the counter to hunting
			if (32'(rx_pos) == 32'(rx_len) + 32'd2)
				rx_pos = SKIP_POS_W'(POS_HUNT);
			else
				rx_pos = rx_pos + 1'b1;
		end else if (rx_type == PKT_PAD) begin
			rx_head[rx_pos[1:0]] = b;
			if (rx_pos >= POS_PAD_END) begin
				r = make_event(KIND_PAD, '0, {rx_head[0], rx_head[1]},
					{rx_head[2], rx_head[3]}, 1'b0, '0);
				hit = 1'b1;
				rx_pos = SKIP_POS_W'(POS_HUNT);
			end else begin
				rx_pos = rx_pos + 1'b1;
			end
		end else if (rx_type == PKT_WRITE) begin
			if (rx_pos < POS_DATA) begin
				rx_head[rx_pos[1:0]] = b;
				rx_pos = rx_pos + 1'b1;
			end else begin
				off = rx_pos - SKIP_POS_W'(POS_DATA);
				last = (off >= SECTOR_BYTES - 1);
				drv = rx_head[0][7];
				// unmounted drive: consume the byte silently
				if (mounted_drives[drv]) begin
					r = make_event(KIND_WRITE, '0, '0, '0, drv, {rx_head[0][6:0], rx_head[1]});
					r.data_byte = b;
					r.byte_index = off[8:0];
					r.last_byte = last;
					hit = 1'b1;
				end
				rx_pos = last ? SKIP_POS_W'(POS_HUNT) : rx_pos + 1'b1;
			end
		end else if (rx_type == PKT_READ) begin
			rx_head[rx_pos[1:0]] = b;
			if (rx_pos >= POS_READ_END) begin
				r = make_event(KIND_READ, '0, '0, '0, rx_head[0][7], {rx_head[0][6:0], rx_head[1]});
				hit = 1'b1;
				rx_pos = SKIP_POS_W'(POS_HUNT);
			end else begin
				rx_pos = rx_pos + 1'b1;
			end
		end else begin
			// unknown type: drop back to hunting
			rx_pos = SKIP_POS_W'(POS_HUNT);
		end
		return hit;
	endfunction

	// Offer one byte, wait for it to be taken, then maybe idle
	task automatic send_byte(input logic [7:0] b, input bit typed, input evt_t want);
		evt_t got;
		bit   hit;
		int   gap;
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		hit = parse_byte(b, got);
		if (typed)
			pending_events.push_back(want);
		else if (hit)
			pending_events.push_back(got);
		bytes_sent++;
		gap = (steady || $urandom_range(99) < 70) ? 0 : stall_len();
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the input until every expected event is out, then let the pipe settle
	task automatic drain();
		rx.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mounted(input logic [1:0] v);
		cfg.valid <= 1'b1;
		cfg.drives_mounted <= v;
		do @(posedge clk); while (!cfg.ready);
		mounted_drives = v;
		cfg.valid <= 1'b0;
	endtask

	// Feed filler until the parser is back to hunting
	task automatic resync();
		while (rx_pos != POS_HUNT) send_byte(8'h00, 1'b0, '0);
	endtask

	function automatic plan_t pick_plan();
		int r;
		r = $urandom_range(99);
		if (r < 16) return PLAN_CORE;
		if (r < 38) return PLAN_PAD;
		if (r < 58) return PLAN_READ;
		if (r < 72) return PLAN_SKIP;
		if (r < 80) return PLAN_ODD;
		return PLAN_NOISE;
	endfunction

	// Build one packet (or a burst of noise) and send it, optionally cut short
	task automatic send_packet(input plan_t plan, input logic drv, input bit cut);
		logic [7:0]  pkt [$];
		logic [7:0]  code;
		logic [7:0]  b;
		logic [15:0] len;
		logic [14:0] sec;
		int          body;
		int          keep;
		len = 16'($urandom_range(16'hFFFF));
		sec = 15'($urandom_range(15'h7FFF));
		code = PKT_CORE;
		body = 1;
		case (plan)
			PLAN_PAD: begin
				code = PKT_PAD;
				body = 4;
			end
			PLAN_READ: begin
				code = PKT_READ;
				body = 2;
			end
			PLAN_WRITE: begin
				code = PKT_WRITE;
				body = 2 + SECTOR_BYTES;
			end
			PLAN_SKIP: begin
				code = PKT_CFG;
				body = $urandom_range(1, 23);
				len = 16'(body + 1);
			end
			PLAN_WRAP: begin
				// short length or one past the counter: both end by wrapping
				code = PKT_CFG;
				body = (1 << SKIP_POS_W) - (POS_TYPE + 1);
				len = $urandom_range(1) ? 16'($urandom_range(1)) :
					16'($urandom_range(1022, 16'hFFFF));
			end
			PLAN_ODD: begin
				do code = 8'($urandom_range(255)); while (code >= PKT_CORE && code <= PKT_READ);
			end
			default: body = 0;
		endcase
		if (plan == PLAN_NOISE) begin
			repeat ($urandom_range(1, 6)) begin
				b = 8'($urandom_range(255));
				pkt.push_back(b == SYNC_BYTE ? ~b : b);
			end
		end else begin
			if (plan != PLAN_SKIP && plan != PLAN_WRAP && $urandom_range(1))
				len = 16'(body);
			pkt = '{SYNC_BYTE, len[15:8], len[7:0], code};
			repeat (body) pkt.push_back(8'($urandom_range(255)));
			if (plan == PLAN_WRITE) begin
				pkt[POS_DATA - 2] = {drv, sec[14:8]};
				pkt[POS_DATA - 1] = sec[7:0];
			end
		end
		if (cut && pkt.size() > 1) begin
			keep = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > keep) void'(pkt.pop_back());
		end
		steady = ($urandom_range(99) < 15);
		foreach (pkt[i]) send_byte(pkt[i], 1'b0, '0);
		steady = 1'b0;
	endtask

	task automatic compare(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Result side: random back-pressure, compare each item against the oldest expectation
	always @(posedge clk) begin
		evt_t want;
		if (arst_n) begin
			if (evt.valid && evt.ready) begin
				if (pending_events.size() == 0) begin
					$display("%0t: event with none expected: kind %0d", $time, evt.event_kind);
					mismatches++;
				end else begin
					want = pending_events.pop_front();
					compare("event_kind", want.event_kind, evt.event_kind);
					compare("core_ident", want.core_ident, evt.core_ident);
					compare("pad_one", want.pad_one, evt.pad_one);
					compare("pad_two", want.pad_two, evt.pad_two);
					compare("drive_sel", want.drive_sel, evt.drive_sel);
					compare("sector_num", want.sector_num, evt.sector_num);
					compare("data_byte", want.data_byte, evt.data_byte);
					compare("byte_index", want.byte_index, evt.byte_index);
					compare("last_byte", want.last_byte, evt.last_byte);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				evt.ready <= 1'b0;
			end else if (steady || $urandom_range(99) < 65) begin
				evt.ready <= 1'b1;
			end else begin
				hold_left = stall_len() - 1;
				evt.ready <= 1'b0;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (cfg.valid && cfg.ready) ||
			(evt.valid && evt.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("link_packet_deframer regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] directed [$];
		evt_t       typed_result [int];
		evt_t       want;
		logic [1:0] phase_cfg [4];
		int         phase_start;

		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.drives_mounted = '0;
		evt.ready = 1'b0;
		rx_pos = SKIP_POS_W'(POS_HUNT);
		rx_len = '0;
		rx_type = '0;
		mounted_drives = '0;
		foreach (rx_head[i]) rx_head[i] = '0;
		mismatches = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		hold_left = 0;
		steady = 1'b0;
		phase_cfg = '{2'b11, 2'b01, 2'b10, 2'b00};

		// Directed table: noise, then core, pad and read packets with extreme payloads, an unknown type and a config skip
		directed = '{8'h00,
			SYNC_BYTE, 8'h00, 8'h01, PKT_CORE, 8'hFF,
			SYNC_BYTE, 8'h00, 8'h04, PKT_PAD, 8'hFF, 8'hFF, 8'h00, 8'h00,
			SYNC_BYTE, 8'h00, 8'h02, PKT_READ, 8'hFF, 8'hFF,
			SYNC_BYTE, 8'h00, 8'h00, 8'hFF, 8'h55,
			SYNC_BYTE, 8'h00, 8'h02, PKT_CFG, 8'h00};
		typed_result[5] = make_event(KIND_CORE, 8'hFF, '0, '0, 1'b0, '0);
		typed_result[13] = make_event(KIND_PAD, '0, 16'hFFFF, 16'h0000, 1'b0, '0);
		typed_result[19] = make_event(KIND_READ, '0, '0, '0, 1'b1, 15'h7FFF);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			want = typed_result.exists(i) ? typed_result[i] : '0;
			send_byte(directed[i], typed_result.exists(i), want);
		end

		// Random phases, one mount setting each, with the long cases placed up front
		foreach (phase_cfg[k]) begin
			drain();
			write_mounted(phase_cfg[k]);
			resync();
			if (phase_cfg[k] == 2'b01) begin
				// start a drive 1 sector while unmounted, then mount it for the rest
				send_packet(PLAN_WRITE, 1'b1, 1'b1);
				drain();
				write_mounted(2'b11);
				resync();
				drain();
				write_mounted(phase_cfg[k]);
			end else if (phase_cfg[k] == 2'b00) begin
				send_packet(PLAN_WRAP, 1'b0, 1'b0);
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				send_packet(pick_plan(), 1'($urandom_range(1)), $urandom_range(99) < 5);
				if ($urandom_range(99) < 4)
					drain();
			end
		end
		drain();

		if (mismatches == 0)
			$display("link_packet_deframer regression: pass");
		else
			$display("link_packet_deframer regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lpd_pkg.sv
rtl/core/lpd_ifs.sv
rtl/core/lpd_in_stage.sv
rtl/core/lpd_parser.sv
rtl/core/lpd_out_stage.sv
rtl/core/link_packet_deframer.sv
test/link_packet_deframer_tb.sv
